>>> rtl/core/rmsprop_param_update_macros.svh
// assertion macros shared by the rmsprop update block
`ifndef RMSPROP_PARAM_UPDATE_MACROS_SVH
`define RMSPROP_PARAM_UPDATE_MACROS_SVH

// same-cycle implication, checked outside reset
`define RMSP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define RMSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/rmsp_pkg.sv
// shared types and constants of the rmsprop update block
package rmsp_pkg;

    localparam int ELEMENT_COUNT = 4096;
    localparam int ADDR_W        = (ELEMENT_COUNT > 1) ? $clog2(ELEMENT_COUNT) : 1;
    localparam int SQRT_STEPS    = 16;
    localparam int DIV_STEPS     = 27;
    localparam int CNT_W         = 5;

    localparam logic [15:0] LR_RESET    = 16'd66;
    localparam logic [15:0] DECAY_RESET = 16'd58982;

    typedef enum logic {
        REG_LEARNING_RATE = 1'b0,
        REG_DECAY_RATE    = 1'b1
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_MUL,
        S_SUM,
        S_WRITE,
        S_SQRT,
        S_DINIT,
        S_DIV,
        S_FIN
    } t_state;

    typedef struct packed {
        logic              load_in;
        logic              load_v;
        logic              mul;
        logic              sum;
        logic              wr_ms;
        logic              sqrt_step;
        logic              div_init;
        logic              div_step;
        logic              out_load;
        logic              clr_we;
        logic [ADDR_W-1:0] clr_addr;
    } t_cmd;

    typedef struct packed {
        logic clearing;
        logic busy;
    } t_stat;

endpackage

>>> rtl/core/rmsp_ram.sv
// generic single-write, registered-read ram
module rmsp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/rmsp_ctrl.sv
// sequencer of the rmsprop update: clearing pass, item steps, output handshake
module rmsp_ctrl import rmsp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    output t_cmd  o_cmd,
    output t_stat o_stat
);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [ADDR_W-1:0] r_clr, n_clr;
    logic              r_out_valid, n_out_valid;
    logic              out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr == ADDR_W'(ELEMENT_COUNT - 1)) n_state = S_IDLE;
            S_IDLE:  if (i_in_valid) n_state = S_LOAD;
            S_LOAD:  n_state = S_MUL;
            S_MUL:   n_state = S_SUM;
            S_SUM:   n_state = S_WRITE;
            S_WRITE: n_state = S_SQRT;
            S_SQRT:  if (r_cnt == CNT_W'(SQRT_STEPS - 1)) n_state = S_DINIT;
            S_DINIT: n_state = S_DIV;
            S_DIV:   if (r_cnt == CNT_W'(DIV_STEPS - 1)) n_state = S_FIN;
            S_FIN:   if (out_free) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    // outputs and counters
    always_comb begin
        o_cmd          = '0;
        o_cmd.clr_addr = r_clr;
        n_cnt          = '0;
        n_clr          = r_clr;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_we = 1'b1;
                n_clr        = r_clr + 1'b1;
            end
            S_IDLE:  o_cmd.load_in = i_in_valid;
            S_LOAD:  o_cmd.load_v = 1'b1;
            S_MUL:   o_cmd.mul = 1'b1;
            S_SUM:   o_cmd.sum = 1'b1;
            S_WRITE: o_cmd.wr_ms = 1'b1;
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_cnt           = r_cnt + 1'b1;
            end
            S_DINIT: o_cmd.div_init = 1'b1;
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
            end
            S_FIN:   o_cmd.out_load = out_free;
            default: o_cmd = '0;
        endcase
        n_out_valid = o_cmd.out_load ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_stat.clearing = (r_state == S_CLEAR);
    assign o_stat.busy     = (r_state != S_IDLE) && (r_state != S_CLEAR);

endmodule

>>> rtl/core/rmsp_dp.sv
// datapath: config registers, mean-square store, multiplies, root, divide, clamp
module rmsp_dp import rmsp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic [11:0] i_element_index,
    input  logic [15:0] i_gradient,
    input  logic [15:0] i_param_value,
    input  t_cmd        i_cmd,
    output logic [15:0] o_new_param,
    output logic        o_saturated
);

    logic [15:0]       r_lr, r_decay;
    logic [ADDR_W-1:0] r_addr;
    logic              r_in_range;
    logic [15:0]       r_grad, r_param, r_mag;
    logic [31:0]       r_v, r_g2, r_num, r_vn;
    logic [47:0]       r_p1, r_p2;
    logic [31:0]       r_sq_v;
    logic [16:0]       r_sq_rem;
    logic [15:0]       r_root;
    logic [26:0]       r_dq;
    logic [16:0]       r_drem, r_den;
    logic [15:0]       r_new_param;
    logic              r_sat;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [31:0]       ram_wdata, ram_rdata;
    logic [15:0]       mag_in;
    logic [16:0]       one_minus_decay;
    logic [48:0]       p2_full;
    logic [48:0]       ms_sum;
    logic [18:0]       sq_rem2, sq_trial;
    logic              sq_ge;
    logic [17:0]       dv_t;
    logic              dv_ge;
    logic [28:0]       np_full;
    logic [28:0]       smag_ext;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr    <= LR_RESET;
            r_decay <= DECAY_RESET;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_LEARNING_RATE: r_lr    <= i_cfg_data;
                REG_DECAY_RATE:    r_decay <= i_cfg_data;
                default:           r_lr    <= r_lr;
            endcase
        end
    end

    // mean-square store with clearing-pass write path
    assign ram_we    = i_cmd.clr_we || (i_cmd.wr_ms && r_in_range);
    assign ram_waddr = i_cmd.clr_we ? i_cmd.clr_addr : r_addr;
    assign ram_wdata = i_cmd.clr_we ? 32'd0 : r_vn;

    rmsp_ram #(
        .WIDTH (32),
        .DEPTH (ELEMENT_COUNT)
    ) u_ms_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ADDR_W'(i_element_index)),
        .o_rdata (ram_rdata)
    );

    assign mag_in          = i_gradient[15] ? 16'(~i_gradient + 16'd1) : i_gradient;
    assign one_minus_decay = 17'h10000 - {1'b0, r_decay};
    assign p2_full         = one_minus_decay * r_g2;
    assign ms_sum          = {1'b0, r_p1} + {1'b0, r_p2};

    // root step: two bits of the radicand per cycle
    assign sq_rem2  = {r_sq_rem, r_sq_v[31:30]};
    assign sq_trial = {1'b0, r_root, 2'b01};
    assign sq_ge    = (sq_rem2 >= sq_trial);

    // restoring divide step: one quotient bit per cycle
    assign dv_t  = {r_drem, r_dq[26]};
    assign dv_ge = (dv_t >= {1'b0, r_den});

    // signed result p - step, clamp below
    assign smag_ext = {2'b00, r_dq};
    assign np_full  = {{13{r_param[15]}}, r_param}
                    + (r_grad[15] ? smag_ext : 29'(~smag_ext + 29'd1));

    always_ff @(posedge i_clk) begin
        // capture item
        if (i_cmd.load_in) begin
            r_addr     <= ADDR_W'(i_element_index);
            r_in_range <= ({20'd0, i_element_index} < 32'(ELEMENT_COUNT));
            r_grad     <= i_gradient;
            r_param    <= i_param_value;
            r_mag      <= mag_in;
        end
        // stored mean square and squared gradient
        if (i_cmd.load_v) begin
            r_v  <= r_in_range ? ram_rdata : 32'd0;
            r_g2 <= r_mag * r_mag;
        end
        // weighted terms and step numerator
        if (i_cmd.mul) begin
            r_p1  <= r_decay * r_v;
            r_p2  <= p2_full[47:0];
            r_num <= r_lr * r_mag;
        end
        // new mean square
        if (i_cmd.sum) begin
            r_vn <= ms_sum[47:16];
        end
        // root start together with the store write
        if (i_cmd.wr_ms) begin
            r_sq_v   <= r_vn;
            r_sq_rem <= '0;
            r_root   <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_sq_v   <= {r_sq_v[29:0], 2'b00};
            r_sq_rem <= sq_ge ? 17'(sq_rem2 - sq_trial) : sq_rem2[16:0];
            r_root   <= {r_root[14:0], sq_ge};
        end
        // divide (lr*|g| / 16) by root + 1
        if (i_cmd.div_init) begin
            r_den  <= {1'b0, r_root} + 17'd1;
            r_drem <= '0;
            r_dq   <= r_num[30:4];
        end else if (i_cmd.div_step) begin
            r_drem <= dv_ge ? 17'(dv_t - {1'b0, r_den}) : dv_t[16:0];
            r_dq   <= {r_dq[25:0], dv_ge};
        end
        // output register
        if (i_cmd.out_load) begin
            if (!np_full[28] && (np_full[27:15] != 13'd0)) begin
                r_new_param <= 16'h7FFF;
                r_sat       <= 1'b1;
            end else if (np_full[28] && (np_full[27:15] != 13'h1FFF)) begin
                r_new_param <= 16'h8000;
                r_sat       <= 1'b1;
            end else begin
                r_new_param <= np_full[15:0];
                r_sat       <= 1'b0;
            end
        end
    end

    assign o_new_param = r_new_param;
    assign o_saturated = r_sat;

endmodule

>>> rtl/core/rmsprop_param_update.sv
// top level of the rmsprop parameter update block
//
//  channel  | signals                                        | direction
//  ---------+------------------------------------------------+----------
//  input    | i_in_valid/o_in_ready, element_index, gradient,| in
//           | param_value                                    |
//  result   | o_out_valid/i_out_ready, new_param, saturated  | out
//  config   | i_cfg_we, i_cfg_index, i_cfg_data              | in
//
// one item runs from transfer to next transfer through the accepting state,
// load, multiply and store update, the bit-pair square root, the divide setup,
// the restoring divide and the result load; no new item is taken meanwhile.
// after reset a clearing pass writes 4096 zero entries, one per cycle,
// before the first item is taken; config writes work meanwhile.
// a finished result waits in the output register while the next item runs;
// the sequencer stalls at the end only if that register is still full.
`include "rmsprop_param_update_macros.svh"

module rmsprop_param_update import rmsp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [11:0] i_element_index,
    input  logic [15:0] i_gradient,
    input  logic [15:0] i_param_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_new_param,
    output logic        o_saturated
);

    t_cmd  cmd;
    t_stat stat;

    rmsp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .o_stat      (stat)
    );

    rmsp_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_element_index (i_element_index),
        .i_gradient      (i_gradient),
        .i_param_value   (i_param_value),
        .i_cmd           (cmd),
        .o_new_param     (o_new_param),
        .o_saturated     (o_saturated)
    );

    // checks
    `RMSP_ASSERT_NOW(a_no_take_while_clearing, i_clk, i_rst_n, stat.clearing, !o_in_ready, "item taken during clear")
    `RMSP_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_in_valid && o_in_ready, stat.busy && !o_in_ready, "not busy after transfer")
    `RMSP_ASSERT_NOW(a_clear_no_store_write, i_clk, i_rst_n, stat.clearing, !cmd.wr_ms, "store update during clear")

endmodule

>>> test/tb_rmsprop_param_update.sv
// testbench for the rmsprop parameter update block: random and directed items vs a predictor
`timescale 1ns / 100ps

module tb_rmsprop_param_update;
    import rmsp_pkg::*;

    // scoreboard: mean-square mirror, register copy, expected update queue
    class update_scoreboard;
        logic [31:0] ms_mirror [ELEMENT_COUNT];
        logic [15:0] lr;
        logic [15:0] decay;
        logic [16:0] expected_q [$];
        int errors;

        function void clear();
            foreach (ms_mirror[k]) ms_mirror[k] = '0;
            lr = LR_RESET;
            decay = DECAY_RESET;
            errors = 0;
            expected_q.delete();
        endfunction

        function void set_reg(t_reg_idx idx, logic [15:0] val);
            if (idx == REG_LEARNING_RATE) lr = val;
            else decay = val;
        endfunction

        function logic [15:0] root_of(logic [31:0] v);
            logic [31:0] rem, root, bitv;
            rem = v;
            root = 0;
            bitv = 32'h4000_0000;
            while (bitv > rem) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (rem >= root + bitv) begin
                    rem = rem - (root + bitv);
                    root = (root >> 1) + bitv;
                end else begin
                    root = root >> 1;
                end
                bitv = bitv >> 2;
            end
            return root[15:0];
        endfunction

        // note an accepted input transfer and predict its update
        function void note_item(logic [11:0] idx, logic [15:0] g, logic [15:0] p);
            logic [63:0] v, mag, vn, d, smag;
            longint gs, ps, np;
            logic sat;
            gs = $signed(g);
            ps = $signed(p);
            v = (idx < ELEMENT_COUNT) ? ms_mirror[idx] : 0;
            mag = (gs < 0) ? -gs : gs;
            vn = (64'(decay) * v + (64'd65536 - 64'(decay)) * mag * mag) >> 16;
            vn = vn & 64'hFFFF_FFFF;
            if (idx < ELEMENT_COUNT) ms_mirror[idx] = vn[31:0];
            d = 64'(root_of(vn[31:0])) + 1;
            smag = (64'(lr) * mag) / (16 * d);
            np = (gs < 0) ? ps + longint'(smag) : ps - longint'(smag);
            sat = 0;
            if (np > 32767) begin
                np = 32767;
                sat = 1;
            end else if (np < -32768) begin
                np = -32768;
                sat = 1;
            end
            expected_q.insert(expected_q.size(), {sat, np[15:0]});
        endfunction

        // check one result transfer against the oldest prediction
        function void check_result(logic [15:0] np, logic sat);
            logic [16:0] e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result new_param=%0d sat=%0b", $time,
                    $signed(np), sat);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (np !== e[15:0]) begin
                $display("%0t: new_param expected %0d actual %0d", $time,
                    $signed(e[15:0]), $signed(np));
                errors++;
            end
            if (sat !== e[16]) begin
                $display("%0t: saturated expected %0b actual %0b", $time, e[16], sat);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic        i_cfg_index = 0;
    logic [15:0] i_cfg_data = 0;
    logic        i_in_valid = 0;
    logic        o_in_ready;
    logic [11:0] i_element_index = 0;
    logic [15:0] i_gradient = 0;
    logic [15:0] i_param_value = 0;
    logic        o_out_valid;
    logic        i_out_ready = 0;
    logic [15:0] o_new_param;
    logic        o_saturated;

    update_scoreboard sb;
    bit quiet_phase = 0;

    rmsprop_param_update dut (.*);

    always #10 i_clk = ~i_clk;

    // sample result transfers at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_new_param, o_saturated);
    end

    // receiver stalls in bursts
    initial begin
        int n;
        forever begin
            @(negedge i_clk);
            if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 0;
                n = $urandom_range(1, 12);
                repeat (n) @(negedge i_clk);
            end
            i_out_ready <= 1;
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    // drive one item until its transfer, with an optional idle burst first;
    // valid drops at the next idle burst or drain, never twice in one step
    task automatic send_item(logic [11:0] idx, logic [15:0] g, logic [15:0] p);
        int n;
        if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 0;
            n = $urandom_range(1, 12);
            repeat (n) @(negedge i_clk);
        end
        i_in_valid <= 1;
        i_element_index <= idx;
        i_gradient <= g;
        i_param_value <= p;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_item(idx, g, p);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    function automatic logic [15:0] rand_field();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($signed($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    // run limit
    initial begin
        #(60_000_000);
        $display("tb_rmsprop_param_update: FAIL");
        $finish;
    end

    initial begin
        logic [11:0] hot [8];
        sb = new();
        sb.clear();
        foreach (hot[k]) hot[k] = 12'($urandom);
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1;

        // directed: extremes, repeated index, saturation
        send_item(12'd0, 16'h7FFF, 16'h8000);
        send_item(12'd4095, 16'h8000, 16'h7FFF);
        send_item(12'd0, 16'h7FFF, 16'h8000);
        send_item(12'd4095, 16'h8000, 16'h7FFF);
        send_item(12'd5, 16'h0000, 16'h1234);
        send_item(12'd5, 16'h0001, 16'hFFFF);
        send_item(12'hAAA, 16'h5555, 16'hAAAA);
        send_item(12'h555, 16'hAAAA, 16'h5555);
        drain();
        write_reg(REG_LEARNING_RATE, 16'hFFFF);
        write_reg(REG_DECAY_RATE, 16'd0);
        send_item(12'd7, 16'h0001, 16'h8001);
        send_item(12'd7, 16'hFFFF, 16'h7FFE);
        send_item(12'd8, 16'h7FFF, 16'h8000);
        send_item(12'd9, 16'h8000, 16'h7FFF);
        drain();
        write_reg(REG_LEARNING_RATE, 16'd0);
        write_reg(REG_DECAY_RATE, 16'hFFFF);
        send_item(12'd7, 16'h7FFF, 16'h7FFF);
        send_item(12'd10, 16'h8000, 16'h8000);
        drain();

        // random phases with differing register settings
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(REG_LEARNING_RATE, (ph % 3 == 0) ? 16'hFFFF : 16'($urandom));
            write_reg(REG_DECAY_RATE, (ph == 2) ? 16'd0 : 16'($urandom));
            if (ph == 7) quiet_phase = 1;
            for (int k = 0; k < 120; k++) begin
                send_item(($urandom_range(0, 2) == 0) ? 12'($urandom) :
                          hot[$urandom_range(0, 7)], rand_field(), rand_field());
            end
            drain();
        end

        if (sb.errors == 0) $display("tb_rmsprop_param_update: PASS");
        else $display("tb_rmsprop_param_update: FAIL");
        $finish;
    end
endmodule
